@@ rtl/mslfo_pkg.sv @@
package mslfo_pkg;

	// Field and register widths
	localparam int STEP_W     = 21;
	localparam int GAIN_W     = 15;
	localparam int MODE_W     = 2;
	localparam int CH_W       = 4;
	localparam int LEVEL_W    = 30;
	localparam int CFG_ADDR_W = 2;
	localparam int CFG_DATA_W = 21;

	// Defaults handed to the top level parameters
	localparam int FRAC_BITS_DEF   = 24;
	localparam int QUEUE_DEPTH_DEF = 4;

	// Gains are Q3.12: round by adding half an LSB, then drop the fraction
	localparam int GAIN_FRAC = 12;

	localparam logic [CH_W-1:0] CH_LAST = {CH_W{1'b1}};

	localparam logic signed [LEVEL_W-1:0] LEVEL_MAX = {1'b0, {(LEVEL_W-1){1'b1}}};
	localparam logic signed [LEVEL_W-1:0] LEVEL_MIN = {1'b1, {(LEVEL_W-1){1'b0}}};

	// Register reset values
	localparam logic [STEP_W-1:0] PHASE_STEP_RST = STEP_W'(152);
	localparam logic [GAIN_W-1:0] SAW_GAIN_RST   = GAIN_W'(4096);
	localparam logic [GAIN_W-1:0] TRI_GAIN_RST   = GAIN_W'(4096);

	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_PHASE_STEP = 2'd0,
		REG_SAW_GAIN   = 2'd1,
		REG_TRI_GAIN   = 2'd2,
		REG_SAW_MODE   = 2'd3
	} cfg_reg_e_t;

	// Saw sign modes; the unused code behaves as all up
	localparam logic [MODE_W-1:0] MODE_UP    = 2'd0;
	localparam logic [MODE_W-1:0] MODE_DOWN  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_SPLIT = 2'd2;

	typedef struct packed {
		logic [STEP_W-1:0] phase_step;
		logic [GAIN_W-1:0] saw_gain;
		logic [GAIN_W-1:0] tri_gain;
		logic [MODE_W-1:0] saw_mode;
	} lfo_cfg_t;

	// Triangle segments: rising through 0..1, falling 1..-1, rising -1..0
	typedef enum logic [2:0] {
		SEG_UP_POS_LO = 3'd0,
		SEG_UP_POS_HI = 3'd1,
		SEG_DN_POS_HI = 3'd2,
		SEG_DN_POS_LO = 3'd3,
		SEG_DN_NEG_LO = 3'd4,
		SEG_DN_NEG_HI = 3'd5,
		SEG_UP_NEG_HI = 3'd6,
		SEG_UP_NEG_LO = 3'd7
	} seg_t;

	typedef struct packed {
		seg_t seg;      // segment the tick started in
		logic saw_rst;  // saw wrapped to minus one on this tick
	} seg_info_t;

	typedef enum logic [1:0] {
		BASE_SAW     = 2'd0,
		BASE_TRI     = 2'd1,
		BASE_NEG_ONE = 2'd2
	} base_sel_t;

	// How one output channel is formed: neg ? -(b + ofs/4) : (b + ofs/4),
	// where b is the selected base, negated when bneg is set
	typedef struct packed {
		base_sel_t         base_sel;
		logic              bneg;
		logic signed [3:0] ofs;
		logic              neg;
	} coef_t;

	// Saw offsets in quarters for 45, 90, ..., 315 degrees
	localparam logic signed [3:0] SAW_OFS [8][7] = '{
		'{ 4'sd1,  4'sd2,  4'sd3, -4'sd4, -4'sd3, -4'sd2, -4'sd1},
		'{ 4'sd1,  4'sd2, -4'sd5, -4'sd4, -4'sd3, -4'sd2, -4'sd1},
		'{ 4'sd1, -4'sd6, -4'sd5, -4'sd4, -4'sd3, -4'sd2, -4'sd1},
		'{-4'sd7, -4'sd6, -4'sd5, -4'sd4, -4'sd3, -4'sd2, -4'sd1},
		'{ 4'sd1,  4'sd2,  4'sd3,  4'sd4,  4'sd5,  4'sd6,  4'sd7},
		'{ 4'sd1,  4'sd2,  4'sd3,  4'sd4,  4'sd5,  4'sd6, -4'sd1},
		'{ 4'sd1,  4'sd2,  4'sd3,  4'sd4,  4'sd5, -4'sd2, -4'sd1},
		'{ 4'sd1,  4'sd2,  4'sd3,  4'sd4, -4'sd3, -4'sd2, -4'sd1}
	};

	// Triangle 45, 90, 135 degrees: negate the triangle, offset in quarters
	localparam logic TRI_NEG [8][3] = '{
		'{1'b0, 1'b1, 1'b1}, '{1'b1, 1'b1, 1'b1}, '{1'b0, 1'b0, 1'b0}, '{1'b0, 1'b0, 1'b1},
		'{1'b0, 1'b1, 1'b1}, '{1'b1, 1'b1, 1'b1}, '{1'b0, 1'b0, 1'b0}, '{1'b0, 1'b0, 1'b1}
	};

	localparam logic signed [3:0] TRI_OFS [8][3] = '{
		'{ 4'sd2,  4'sd4,  4'sd2}, '{ 4'sd6,  4'sd4,  4'sd2},
		'{-4'sd2, -4'sd4, -4'sd6}, '{-4'sd2, -4'sd4, -4'sd2},
		'{-4'sd2, -4'sd4, -4'sd2}, '{-4'sd6, -4'sd4, -4'sd2},
		'{ 4'sd2,  4'sd4,  4'sd6}, '{ 4'sd2,  4'sd4,  4'sd2}
	};

	// Channel order: saws 45,0,315,270,225,180,135,90 then triangles
	// 135,90,45,0 and their inversions
	function automatic coef_t chan_coef(input seg_t seg, input logic saw_rst,
			input logic [CH_W-1:0] ch, input logic [MODE_W-1:0] mode);
		coef_t      c;
		logic [2:0] idx;
		logic [1:0] k;
		logic       neg_lo;
		logic       neg_hi;
		neg_lo = (mode == MODE_DOWN);
		neg_hi = (mode == MODE_DOWN) || (mode == MODE_SPLIT);
		idx    = 3'(4'd8 - ch);
		k      = 2'(2'd2 - ch[1:0]);
		c.base_sel = BASE_SAW;
		c.bneg     = 1'b0;
		c.ofs      = 4'sd0;
		c.neg      = 1'b0;
		if (!ch[3]) begin
			c.neg = ch[2] ? neg_hi : neg_lo;
			priority if (ch == 4'd0) begin
				c.ofs = SAW_OFS[seg][0];
			end else if (ch == 4'd1) begin
				if (saw_rst) begin
					c.base_sel = BASE_NEG_ONE;
				end
			end else begin
				c.ofs = SAW_OFS[seg][idx];
			end
		end else begin
			c.base_sel = BASE_TRI;
			c.neg      = ch[2];
			if (ch[1:0] != 2'd3) begin
				c.bneg = TRI_NEG[seg][k];
				c.ofs  = TRI_OFS[seg][k];
			end
		end
		return c;
	endfunction

endpackage

@@ rtl/mslfo_fifo.sv @@
module mslfo_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_END = PTR_W'(DEPTH - 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PTR_END) ? '0 : PTR_W'(wr_ptr_q + 1'b1);
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PTR_END) ? '0 : PTR_W'(rd_ptr_q + 1'b1);
			end
			unique case ({wr_en, rd_en})
				2'b10:   count_q <= CNT_W'(count_q + 1'b1);
				2'b01:   count_q <= CNT_W'(count_q - 1'b1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ rtl/mslfo_front.sv @@
module mslfo_front #(
	parameter int FRAC_BITS = mslfo_pkg::FRAC_BITS_DEF,
	parameter int PH_W      = FRAC_BITS + 5
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic                   advance,
	input  mslfo_pkg::lfo_cfg_t    cfg,
	input  logic                   q_full,
	output logic                   push,
	output logic signed [PH_W-1:0] push_tri,
	output logic signed [PH_W-1:0] push_saw,
	output mslfo_pkg::seg_info_t   push_info
);

	localparam logic signed [PH_W-1:0] ONE  = PH_W'(1) <<< FRAC_BITS;
	localparam logic signed [PH_W-1:0] HALF = PH_W'(1) <<< (FRAC_BITS - 1);

	mslfo_pkg::seg_t       seg_q;
	mslfo_pkg::seg_t       seg_nx;
	logic signed [PH_W-1:0] tri_q;
	logic signed [PH_W-1:0] saw_q;
	logic signed [PH_W-1:0] tri_nx;
	logic signed [PH_W-1:0] saw_nx;
	logic signed [PH_W-1:0] step_x;
	logic signed [PH_W-1:0] tri_sum;
	logic signed [PH_W-1:0] saw_sum;
	logic                   falling;
	logic                   saw_rst;
	logic                   tick;

	assign in_ready = !q_full;
	// ticks with advance low are dropped here and never reach the queue
	assign tick     = in_valid && in_ready && advance;
	assign push     = tick;

	assign step_x  = $signed({{(PH_W-mslfo_pkg::STEP_W){1'b0}}, cfg.phase_step});
	assign falling = (seg_q == mslfo_pkg::SEG_DN_POS_HI) || (seg_q == mslfo_pkg::SEG_DN_POS_LO) ||
	                 (seg_q == mslfo_pkg::SEG_DN_NEG_LO) || (seg_q == mslfo_pkg::SEG_DN_NEG_HI);
	assign tri_sum = falling ? (tri_q - step_x) : (tri_q + step_x);
	assign saw_sum = saw_q + (step_x >>> 1);

	always_comb begin
		seg_nx  = seg_q;
		tri_nx  = tri_sum;
		saw_nx  = saw_sum;
		saw_rst = 1'b0;
		unique case (seg_q)
			mslfo_pkg::SEG_UP_POS_LO: begin
				if (tri_sum > HALF) seg_nx = mslfo_pkg::SEG_UP_POS_HI;
			end
			mslfo_pkg::SEG_UP_POS_HI: begin
				if (tri_sum > ONE) begin
					seg_nx = mslfo_pkg::SEG_DN_POS_HI;
					tri_nx = ONE;
				end
			end
			mslfo_pkg::SEG_DN_POS_HI: begin
				if (tri_sum < HALF) seg_nx = mslfo_pkg::SEG_DN_POS_LO;
			end
			mslfo_pkg::SEG_DN_POS_LO: begin
				if (tri_sum < 0) begin
					seg_nx  = mslfo_pkg::SEG_DN_NEG_LO;
					saw_nx  = -ONE;
					saw_rst = 1'b1;
				end
			end
			mslfo_pkg::SEG_DN_NEG_LO: begin
				if (tri_sum < -HALF) seg_nx = mslfo_pkg::SEG_DN_NEG_HI;
			end
			mslfo_pkg::SEG_DN_NEG_HI: begin
				if (tri_sum < -ONE) begin
					seg_nx = mslfo_pkg::SEG_UP_NEG_HI;
					tri_nx = -ONE;
				end
			end
			mslfo_pkg::SEG_UP_NEG_HI: begin
				if (tri_sum > -HALF) seg_nx = mslfo_pkg::SEG_UP_NEG_LO;
			end
			mslfo_pkg::SEG_UP_NEG_LO: begin
				if (tri_sum > 0) seg_nx = mslfo_pkg::SEG_UP_POS_LO;
			end
			default: seg_nx = seg_q;
		endcase
	end

	// shifted saws use the saw before its wrap, so push the sum itself
	assign push_tri          = tri_nx;
	assign push_saw          = saw_sum;
	assign push_info.seg     = seg_q;
	assign push_info.saw_rst = saw_rst;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_q <= mslfo_pkg::SEG_UP_POS_LO;
			tri_q <= '0;
			saw_q <= '0;
		end else if (tick) begin
			seg_q <= seg_nx;
			tri_q <= tri_nx;
			saw_q <= saw_nx;
		end
	end

endmodule

@@ rtl/mslfo_back.sv @@
module mslfo_back #(
	parameter int FRAC_BITS = mslfo_pkg::FRAC_BITS_DEF,
	parameter int PH_W      = FRAC_BITS + 5
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  mslfo_pkg::lfo_cfg_t                    cfg,
	input  logic                                   q_valid,
	input  logic signed [PH_W-1:0]                 q_tri,
	input  logic signed [PH_W-1:0]                 q_saw,
	input  mslfo_pkg::seg_info_t                   q_info,
	output logic                                   pop,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic [mslfo_pkg::CH_W-1:0]             channel,
	output logic signed [mslfo_pkg::LEVEL_W-1:0]   level,
	output logic                                   last
);

	localparam int CH_W = mslfo_pkg::CH_W;
	localparam int WV_W = PH_W + 1;
	localparam int WX_W = PH_W + 2;
	localparam int WP_W = WX_W + mslfo_pkg::GAIN_W + 1;

	localparam logic signed [PH_W-1:0] ONE   = PH_W'(1) <<< FRAC_BITS;
	localparam logic signed [WX_W-1:0] ONE_X = WX_W'(1) <<< FRAC_BITS;
	localparam logic signed [WP_W-1:0] RND   = WP_W'(1) <<< (mslfo_pkg::GAIN_FRAC - 1);
	localparam logic signed [WP_W-1:0] LMAX  = WP_W'(mslfo_pkg::LEVEL_MAX);
	localparam logic signed [WP_W-1:0] LMIN  = WP_W'(mslfo_pkg::LEVEL_MIN);

	logic [CH_W-1:0]                     ch_q;
	logic                                en;
	logic                                issue;
	mslfo_pkg::coef_t                    coef;
	logic signed [PH_W-1:0]              base;
	logic signed [WV_W-1:0]              bterm;
	logic signed [WV_W-1:0]              oterm;
	logic signed [WV_W-1:0]              w;

	logic                                valid_s1;
	logic [CH_W-1:0]                     ch_s1;
	logic                                neg_s1;
	logic signed [WV_W-1:0]              w_s1;

	logic                                valid_s2;
	logic [CH_W-1:0]                     ch_s2;
	logic signed [WX_W-1:0]              x_s2;
	logic [mslfo_pkg::GAIN_W-1:0]        gain_s2;

	logic                                valid_s3;
	logic [CH_W-1:0]                     ch_s3;
	logic signed [WP_W-1:0]              p_s3;

	logic signed [WP_W-1:0]              rnd;
	logic signed [mslfo_pkg::LEVEL_W-1:0] sat;

	logic                                out_valid_q;
	logic [CH_W-1:0]                     channel_q;
	logic signed [mslfo_pkg::LEVEL_W-1:0] level_q;

	// whole pipeline holds while the output word waits
	assign en    = !out_valid_q || out_ready;
	assign issue = en && q_valid;
	assign pop   = issue && (ch_q == mslfo_pkg::CH_LAST);

	assign coef = mslfo_pkg::chan_coef(q_info.seg, q_info.saw_rst, ch_q, cfg.saw_mode);

	always_comb begin
		unique case (coef.base_sel)
			mslfo_pkg::BASE_SAW:     base = q_saw;
			mslfo_pkg::BASE_TRI:     base = q_tri;
			mslfo_pkg::BASE_NEG_ONE: base = -ONE;
			default:                 base = q_saw;
		endcase
	end

	assign bterm = coef.bneg ? -WV_W'(base) : WV_W'(base);
	assign oterm = WV_W'(coef.ofs) <<< (FRAC_BITS - 2);
	assign w     = bterm + oterm;

	assign rnd = (p_s3 + RND) >>> mslfo_pkg::GAIN_FRAC;

	always_comb begin
		priority if (rnd > LMAX) begin
			sat = mslfo_pkg::LEVEL_MAX;
		end else if (rnd < LMIN) begin
			sat = mslfo_pkg::LEVEL_MIN;
		end else begin
			sat = rnd[mslfo_pkg::LEVEL_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ch_q        <= '0;
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			if (issue) begin
				ch_q <= CH_W'(ch_q + 1'b1);
			end
			valid_s1    <= issue;
			valid_s2    <= valid_s1;
			valid_s3    <= valid_s2;
			out_valid_q <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ch_s1     <= ch_q;
			neg_s1    <= coef.neg;
			w_s1      <= w;
			ch_s2     <= ch_s1;
			x_s2      <= neg_s1 ? (ONE_X - WX_W'(w_s1)) : (ONE_X + WX_W'(w_s1));
			// channel msb marks the triangle half
			gain_s2   <= ch_s1[CH_W-1] ? cfg.tri_gain : cfg.saw_gain;
			ch_s3     <= ch_s2;
			p_s3      <= WP_W'(x_s2) * WP_W'($signed({1'b0, gain_s2}));
			channel_q <= ch_s3;
			level_q   <= sat;
		end
	end

	assign out_valid = out_valid_q;
	assign channel   = channel_q;
	assign level     = level_q;
	assign last      = (channel_q == mslfo_pkg::CH_LAST);

endmodule

@@ rtl/multiphase_saw_triangle_lfo_top.sv @@
// Eight-phase saw and triangle LFO. Each accepted word with advance high is
// one sample tick: it moves the triangle and saw phases one step and yields
// sixteen output words in channel order, saws 0-7 then triangles 8-15, with
// last set on channel 15. A word with advance low is dropped and yields
// nothing. The front end updates the phase state and takes one tick per
// cycle while its tick queue (QUEUE_DEPTH entries) has room; the back end
// forms one channel per cycle while the output is not stalled, through a
// single gain multiplier. The first word of a tick passes through the tick
// queue, the back end stages s1, s2 and s3 and the output register. Write
// the registers only while no tick is in flight.
module multiphase_saw_triangle_lfo_top #(
	parameter int FRAC_BITS   = mslfo_pkg::FRAC_BITS_DEF,
	parameter int QUEUE_DEPTH = mslfo_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [mslfo_pkg::CFG_ADDR_W-1:0]     cfg_addr,
	input  logic [mslfo_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic                                 advance,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [mslfo_pkg::CH_W-1:0]           channel,
	output logic signed [mslfo_pkg::LEVEL_W-1:0] level,
	output logic                                 last
);

	// Phase width: room for the step at any fraction size, plus headroom
	// for the clamp overshoot and the saw drift between wraps
	localparam int PH_W = ((FRAC_BITS > mslfo_pkg::STEP_W) ? FRAC_BITS : mslfo_pkg::STEP_W) + 5;
	localparam int Q_W  = 2 * PH_W + $bits(mslfo_pkg::seg_info_t);

	mslfo_pkg::lfo_cfg_t    cfg_q;

	logic                   push;
	logic signed [PH_W-1:0] push_tri;
	logic signed [PH_W-1:0] push_saw;
	mslfo_pkg::seg_info_t   push_info;
	logic                   q_full;
	logic                   q_empty;
	logic                   pop;
	logic [Q_W-1:0]         q_rd;
	logic signed [PH_W-1:0] q_tri;
	logic signed [PH_W-1:0] q_saw;
	mslfo_pkg::seg_info_t   q_info;

	// Register bank: writes land at once, wider data is cut to the field
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.phase_step <= mslfo_pkg::PHASE_STEP_RST;
			cfg_q.saw_gain   <= mslfo_pkg::SAW_GAIN_RST;
			cfg_q.tri_gain   <= mslfo_pkg::TRI_GAIN_RST;
			cfg_q.saw_mode   <= mslfo_pkg::MODE_UP;
		end else if (cfg_we) begin
			unique case (mslfo_pkg::cfg_reg_e_t'(cfg_addr))
				mslfo_pkg::REG_PHASE_STEP: cfg_q.phase_step <= cfg_wdata[mslfo_pkg::STEP_W-1:0];
				mslfo_pkg::REG_SAW_GAIN:   cfg_q.saw_gain   <= cfg_wdata[mslfo_pkg::GAIN_W-1:0];
				mslfo_pkg::REG_TRI_GAIN:   cfg_q.tri_gain   <= cfg_wdata[mslfo_pkg::GAIN_W-1:0];
				mslfo_pkg::REG_SAW_MODE:   cfg_q.saw_mode   <= cfg_wdata[mslfo_pkg::MODE_W-1:0];
				default:                   cfg_q            <= cfg_q;
			endcase
		end
	end

	// Front end: take ticks, advance the segment machine, queue the phases
	mslfo_front #(
		.FRAC_BITS (FRAC_BITS),
		.PH_W      (PH_W)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.advance   (advance),
		.cfg       (cfg_q),
		.q_full    (q_full),
		.push      (push),
		.push_tri  (push_tri),
		.push_saw  (push_saw),
		.push_info (push_info)
	);

	// Tick queue: lets the front run ahead while the back drains 16 words
	mslfo_fifo #(
		.WIDTH (Q_W),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (push),
		.wr_data ({push_tri, push_saw, push_info}),
		.full    (q_full),
		.rd_en   (pop),
		.rd_data (q_rd),
		.empty   (q_empty)
	);

	assign {q_tri, q_saw, q_info} = q_rd;

	// Back end: per channel offset, gain, round, saturate; pop on issuing channel 15
	mslfo_back #(
		.FRAC_BITS (FRAC_BITS),
		.PH_W      (PH_W)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_valid   (!q_empty),
		.q_tri     (q_tri),
		.q_saw     (q_saw),
		.q_info    (q_info),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.channel   (channel),
		.level     (level),
		.last      (last)
	);

endmodule

@@ rtl/mslfo_checker.sv @@
module mslfo_checker (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 in_valid,
	input logic                                 in_ready,
	input logic                                 advance,
	input logic                                 out_valid,
	input logic                                 out_ready,
	input logic [mslfo_pkg::CH_W-1:0]           channel,
	input logic signed [mslfo_pkg::LEVEL_W-1:0] level,
	input logic                                 last
);

	logic [mslfo_pkg::CH_W-1:0] exp_ch_q;
	logic [3:0]                 pend_q;
	logic                       tick_in;
	logic                       tick_out;

	assign tick_in  = in_valid && in_ready && advance;
	assign tick_out = out_valid && out_ready && last;

	// track the channel due next and the ticks taken but not yet finished
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_ch_q <= '0;
			pend_q   <= '0;
		end else begin
			if (out_valid && out_ready) begin
				exp_ch_q <= mslfo_pkg::CH_W'(channel + 1'b1);
			end
			unique case ({tick_in, tick_out})
				2'b10:   pend_q <= 4'(pend_q + 1'b1);
				2'b01:   pend_q <= 4'(pend_q - 1'b1);
				default: pend_q <= pend_q;
			endcase
		end
	end

	a_channel_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> channel == exp_ch_q)
		else $error("output channel out of sequence");

	a_last_on_final: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last == (channel == mslfo_pkg::CH_LAST)))
		else $error("last flag does not match channel 15");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pend_q != 4'd0)
		else $error("output word without a pending tick");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(channel) && $stable(level))
		else $error("stalled output word changed");

endmodule

bind multiphase_saw_triangle_lfo_top mslfo_checker u_mslfo_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.advance   (advance),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.channel   (channel),
	.level     (level),
	.last      (last)
);
